// ----- design/lbpr_pkg.sv -----
// Package for the longest balanced parenthesis run core.
// Holds the payload structs, the internal operation type and shared constants.
// No dependencies.
package lbpr_pkg;

    localparam int POS_W           = 16;
    localparam int DEF_STACK_DEPTH = 1024;
    localparam int DEF_MAX_LEN     = 65535;
    localparam int Q_DEPTH         = 2;
    localparam int Q_PW            = $clog2(Q_DEPTH);
    localparam int Q_CW            = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] OPEN_SYMBOL = 8'h28;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [15:0] best_length;
        logic        end_of_string;
        logic        error;
    } result_t;

    // Classified character as it travels from the front to the back part.
    typedef struct packed {
        logic is_open;
        logic last;
    } op_t;

endpackage

// ----- design/lbpr_front.sv -----
// Front part: accepts characters, classifies them as open or close and
// queues them for the back part. Depends on lbpr_pkg.
module lbpr_front
    import lbpr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  item_t item,
    output logic  op_valid,
    input  logic  op_pop,
    output op_t   op
);

    op_t              queue_reg [Q_DEPTH];
    logic [Q_PW-1:0]  wr_ptr_reg;
    logic [Q_PW-1:0]  rd_ptr_reg;
    logic [Q_CW-1:0]  count_reg;
    logic             push;
    logic             pop;

    assign item_stall = (count_reg == Q_CW'(Q_DEPTH));
    assign push       = item_valid && !item_stall;
    assign op_valid   = (count_reg != '0);
    assign pop        = op_pop && op_valid;
    assign op         = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg].is_open <= (item.symbol == OPEN_SYMBOL);
            queue_reg[wr_ptr_reg].last    <= item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/lbpr_back.sv -----
// Back part: the stack engine with its position memory, and the output
// register that holds one result transaction. Depends on lbpr_pkg.
module lbpr_back
    import lbpr_pkg::*;
#(
    parameter int STACK_DEPTH    = DEF_STACK_DEPTH,
    parameter int MAX_STRING_LEN = DEF_MAX_LEN
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    op_valid,
    output logic    op_pop,
    input  op_t     op,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [POS_W-1:0] mem [STACK_DEPTH];
    logic [POS_W-1:0] second_reg;  // always holds the entry just below the top

    logic [CW-1:0]    cnt_reg,  cnt_next;
    logic [POS_W-1:0] base_reg, base_next;  // base position plus one
    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [15:0]      best_reg, best_next;
    logic             err_reg,  err_next;
    logic             out_valid_reg;
    result_t          result_reg, result_next;

    logic             fire;
    logic             pos_ovf;
    logic             full;
    logic             do_push;
    logic [15:0]      run_len;
    logic [AW-1:0]    rd_addr;

    assign fire    = op_valid && (!out_valid_reg || !result_stall);
    assign op_pop  = fire;
    assign pos_ovf = (pos_reg >= POS_W'(MAX_STRING_LEN));
    assign full    = (cnt_reg == CW'(STACK_DEPTH));
    assign do_push = fire && !pos_ovf && op.is_open && !full;
    assign run_len = (cnt_reg == CW'(1)) ? 16'(pos_reg + 1'b1 - base_reg)
                                         : 16'(pos_reg - second_reg);

    always_comb
    begin
        cnt_next    = cnt_reg;
        base_next   = base_reg;
        pos_next    = pos_reg;
        best_next   = best_reg;
        err_next    = err_reg;
        result_next = result_reg;
        if (fire)
        begin
            if (pos_ovf)
            begin
                err_next = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (op.is_open)
                begin
                    if (full)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                else if (cnt_reg == '0)
                begin
                    base_next = pos_reg + 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (run_len > best_reg)
                    begin
                        best_next = run_len;
                    end
                end
            end
            result_next.best_length   = best_next;
            result_next.end_of_string = op.last;
            result_next.error         = err_next;
            if (op.last)
            begin
                cnt_next  = '0;
                base_next = '0;
                pos_next  = '0;
                best_next = '0;
                err_next  = 1'b0;
            end
        end
    end

    // The read address follows the next stack count, so the entry below the
    // top is ready in second_reg for a close in the following cycle. It meets
    // the write address, the current count, only when an open ends the string.
    assign rd_addr = AW'(cnt_next - CW'(2));

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[cnt_reg[AW-1:0]] <= pos_reg;
        end
        second_reg <= mem[rd_addr];
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            base_reg      <= '0;
            pos_reg       <= '0;
            best_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            base_reg <= base_next;
            pos_reg  <= pos_next;
            best_reg <= best_next;
            err_reg  <= err_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

// ----- design/longest_balanced_paren_run_core.sv -----
// Longest balanced parenthesis run core.
// The item channel takes one character transaction (symbol, last) per cycle
// on item_valid/item_stall; a transaction is taken when valid is high and
// stall is low. Symbol 0x28 opens, every other byte closes.
// The result channel gives exactly one transaction per character on
// result_valid/result_stall: the best balanced run so far in the string,
// end_of_string copied from last, and a sticky error flag for stack or
// position overflow. After a character marked last, the string state clears.
// Throughput is one character per cycle while the receiver does not stall;
// the stack engine's entry below the top is prefetched from the position memory.
// A character accepted on the item channel is registered in the two-entry
// classifier queue, processed by the engine straight out of that queue, and
// its result is held in an output register that drives result_valid.
// When the receiver stalls, the result register holds and the engine stops;
// item_stall rises once both queue entries are full, so nothing is lost.
// Reset (rst_n low, asynchronous) empties the queue and output register and
// clears all string state; the stack memory itself needs no clearing.
// Depends on lbpr_pkg, lbpr_front and lbpr_back.
module longest_balanced_paren_run_core
    import lbpr_pkg::*;
#(
    parameter int STACK_DEPTH    = DEF_STACK_DEPTH,
    parameter int MAX_STRING_LEN = DEF_MAX_LEN
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic op_valid;
    logic op_pop;
    op_t  op;

    lbpr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .op_valid   (op_valid),
        .op_pop     (op_pop),
        .op         (op)
    );

    lbpr_back #(
        .STACK_DEPTH    (STACK_DEPTH),
        .MAX_STRING_LEN (MAX_STRING_LEN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid),
        .op_pop       (op_pop),
        .op           (op),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- tb/sv/lbpr_checker.sv -----
`timescale 1ns / 100ps
// Checker for the longest balanced parenthesis run core: it watches both channels,
// predicts every result transaction from the accepted characters and compares them.
// Depends on lbpr_pkg for the payload structs and the open symbol.
module lbpr_checker
    import lbpr_pkg::*;
#(
    parameter int STACK_DEPTH    = DEF_STACK_DEPTH,
    parameter int MAX_STRING_LEN = DEF_MAX_LEN
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      pending,
    output int      fail_count
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    // Predicted string state; the base is held as base + 1 so that zero means -1.
    logic [15:0]      open_stack [STACK_DEPTH];
    logic [CNT_W-1:0] open_count;
    logic [16:0]      base_plus1;
    logic [15:0]      next_pos;
    logic [15:0]      best_run;
    logic             overflowed;

    result_t expected_runs [$];
    int      mismatch_total = 0;

    assign fail_count = mismatch_total;

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_total++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    function automatic void clear_string();
        open_count = '0;
        base_plus1 = '0;
        next_pos   = '0;
        best_run   = '0;
        overflowed = 1'b0;
    endfunction

    function automatic result_t advance_string(input item_t tr);
        result_t     res;
        logic [16:0] run_len;
        if (next_pos >= MAX_STRING_LEN) begin
            // Past the longest string only the error flag moves.
            overflowed = 1'b1;
        end
        else begin
            if (tr.symbol == OPEN_SYMBOL) begin
                if (open_count >= STACK_DEPTH) begin
                    overflowed = 1'b1;
                end
                else begin
                    open_stack[IDX_W'(open_count)] = next_pos;
                    open_count = open_count + 1'b1;
                end
            end
            else if (open_count == 0) begin
                base_plus1 = {1'b0, next_pos} + 17'd1;
            end
            else begin
                open_count = open_count - 1'b1;
                if (open_count == 0)
                    run_len = {1'b0, next_pos} + 17'd1 - base_plus1;
                else
                    run_len = {1'b0, next_pos}
                              - {1'b0, open_stack[IDX_W'(open_count - 1'b1)]};
                if (run_len > {1'b0, best_run})
                    best_run = run_len[15:0];
            end
            next_pos = next_pos + 16'd1;
        end
        res.best_length   = best_run;
        res.end_of_string = tr.last;
        res.error         = overflowed;
        if (tr.last)
            clear_string();
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n) begin
            clear_string();
            expected_runs.delete();
            pending <= 0;
        end
        else begin
            if (result_valid && !result_stall) begin
                if (expected_runs.size() == 0) begin
                    report("result transaction with nothing expected");
                end
                else begin
                    want = expected_runs.pop_front();
                    check_field("best_length", result.best_length, want.best_length);
                    check_field("end_of_string", 16'(result.end_of_string),
                                16'(want.end_of_string));
                    check_field("error", 16'(result.error), 16'(want.error));
                end
            end
            if (item_valid && !item_stall)
                expected_runs.push_back(advance_string(item));
            pending <= expected_runs.size();
        end
    end

endmodule

// ----- tb/sv/tb_longest_balanced_paren_run_core.sv -----
`timescale 1ns / 100ps
// Top of the testbench for the longest balanced parenthesis run core: clock, reset,
// character stimulus, receiver stalls, watchdog and verdict.
// Depends on lbpr_pkg, lbpr_checker and the core itself.
module tb_longest_balanced_paren_run_core;
    import lbpr_pkg::*;

    localparam int STACK_DEPTH    = DEF_STACK_DEPTH;
    localparam int MAX_STRING_LEN = DEF_MAX_LEN;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [7:0] CLOSE_SYMBOL = 8'h29;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    int sender_gap_pct = 0;
    int stall_pct      = 0;
    int idle_cycles    = 0;
    int pending;
    int fail_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    longest_balanced_paren_run_core #(
        .STACK_DEPTH    (STACK_DEPTH),
        .MAX_STRING_LEN (MAX_STRING_LEN)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    lbpr_checker #(
        .STACK_DEPTH    (STACK_DEPTH),
        .MAX_STRING_LEN (MAX_STRING_LEN)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .pending      (pending),
        .fail_count   (fail_count)
    );

    always @(posedge clk)
        result_stall <= ($urandom_range(0, 99) < stall_pct);

    // Any transaction on either channel counts as progress.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    task automatic send_char(input logic [7:0] sym, input logic fin);
        item_t tr;
        tr.symbol = sym;
        tr.last   = fin;
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= tr;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    // The count from the checker is registered, so the last transaction is
    // counted before the wait begins.
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly a plain close bracket, now and then some other non-opening byte.
    function automatic logic [7:0] pick_closer();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0 || b == OPEN_SYMBOL)
            b = CLOSE_SYMBOL;
        return b;
    endfunction

    // Sends one string; returns its length. Most strings are near-balanced walks,
    // some are unbiased brackets and a few are raw bytes.
    task automatic send_random_string(output int len);
        int         mode;
        int         depth;
        logic [7:0] sym;
        mode  = $urandom_range(0, 9);
        len   = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        depth = 0;
        for (int i = 0; i < len; i++) begin
            if (mode < 7) begin
                if (depth == 0)
                    sym = ($urandom_range(0, 99) < 75) ? OPEN_SYMBOL : pick_closer();
                else if (len - i <= depth)
                    sym = pick_closer();
                else
                    sym = $urandom_range(0, 1) ? OPEN_SYMBOL : pick_closer();
            end
            else if (mode < 9) begin
                sym = $urandom_range(0, 1) ? OPEN_SYMBOL : pick_closer();
            end
            else begin
                sym = 8'($urandom_range(0, 255));
            end
            if (sym == OPEN_SYMBOL)
                depth++;
            else if (depth > 0)
                depth--;
            send_char(sym, i == len - 1);
        end
    endtask

    task automatic run_random(input int count);
        int done;
        int len;
        done = 0;
        while (done < count) begin
            send_random_string(len);
            done += len;
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_gap_pct = 14;
        stall_pct      = 66;

        send_text("()");
        send_text(")");
        send_text("((");
        send_text(")()())");
        send_text("(()");
        send_text("(())");
        // Closers that are not ')' and a close on an empty stack ending the string.
        send_char(OPEN_SYMBOL, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(OPEN_SYMBOL, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h27, 1'b0);
        send_char(8'hD7, 1'b1);

        // More opens than the stack holds, then a few closes from the full stack.
        for (int i = 0; i < STACK_DEPTH + 2; i++)
            send_char(OPEN_SYMBOL, 1'b0);
        for (int i = 0; i < 4; i++)
            send_char(CLOSE_SYMBOL, i == 3);

        wait_drained();
        run_random(280);
        wait_drained();

        sender_gap_pct = 66;
        stall_pct      = 14;
        run_random(280);
        wait_drained();

        sender_gap_pct = 0;
        stall_pct      = 0;
        run_random(290);

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
